/* src/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/iac_pkg.sv */
// Shared types and constants of the intrusion alarm controller.
// Depends on nothing; used by every module and the testbench.
package iac_pkg;

   localparam int SEQUENCE_LENGTH = 3;

   typedef enum logic [1:0] {
      MODE_DISARMED = 2'd0,
      MODE_EXIT     = 2'd1,
      MODE_ARMED    = 2'd2,
      MODE_ALARM    = 2'd3
   } mode_type;

   typedef enum logic {
      CFG_EXIT_DELAY  = 1'b0,
      CFG_KEY_TIMEOUT = 1'b1
   } cfg_index_type;

   localparam logic [1:0] KEY_NONE  = 2'd0;
   localparam logic [1:0] KEY_ONE   = 2'd1;
   localparam logic [1:0] KEY_TWO   = 2'd2;
   localparam logic [1:0] KEY_THREE = 2'd3;

   // position of the last key of a sequence
   localparam logic [1:0] LAST_KEY_POS = 2'(SEQUENCE_LENGTH - 1);

   localparam logic [15:0] EXIT_DELAY_RESET  = 16'd10000;
   localparam logic [15:0] KEY_TIMEOUT_RESET = 16'd3000;

   localparam logic [8:0]  BLINK_HALF_MS   = 9'd300;
   localparam logic [10:0] SIREN_PERIOD_MS = 11'd1600;
   localparam logic [10:0] SIREN_OFF1_MS   = 11'd300;
   localparam logic [10:0] SIREN_ON2_MS    = 11'd500;
   localparam logic [10:0] SIREN_OFF2_MS   = 11'd800;

   typedef struct packed {
      logic arm;
      logic disarm;
   } key_event_type;

   typedef struct packed {
      mode_type mode;
      logic     armed_led;
      logic     disarmed_led;
      logic     buzzer;
   } result_type;

endpackage

/* src/iac_if.sv */
// Request and response channel interfaces of the alarm controller.
// Plain valid/ready handshake; depends on nothing.
interface iac_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] button;
   logic       motion;
   modport source (output valid, button, motion, input ready);
   modport sink (input valid, button, motion, output ready);
endinterface

interface iac_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic       armed_led;
   logic       disarmed_led;
   logic       buzzer;
   modport source (output valid, mode, armed_led, disarmed_led, buzzer, input ready);
   modport sink (input valid, mode, armed_led, disarmed_led, buzzer, output ready);
endinterface

/* src/intrusion_alarm_controller.sv */
// Intrusion alarm controller, one request per millisecond tick.
// An accepted request waits in the input register until the result stage is free or
// being emptied; its result then goes to the result register and is the response.
// Throughput: one request per cycle while responses are taken; the input register
// refills while a response waits. Reset: synchronous, active high; clears modes,
// timers, keys, valid flags and loads exit delay 10000 ms and key timeout 3000 ms.
`include "assert_macros.svh"

module intrusion_alarm_controller (
   input  logic          clock,
   input  logic          reset,
   iac_req_if.sink       req_if,
   iac_rsp_if.source     rsp_if,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [15:0]   csr_wdata
);
   import iac_pkg::*;

   // configuration registers
   logic [15:0] exit_delay_ff, exit_delay_in;
   logic [15:0] key_timeout_ff, key_timeout_in;

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [1:0] button_ff;
   logic       motion_ff;

   // result stage
   logic       out_valid_ff, out_valid_in;
   result_type result_ff;

   logic          req_accept;
   logic          step;       // input stage item is processed this cycle
   key_event_type key_event;
   result_type    result;

   // config writes: plain decoder on the register index
   always_comb begin
      exit_delay_in  = exit_delay_ff;
      key_timeout_in = key_timeout_ff;
      if (csr_we) begin
         unique case (cfg_index_type'(csr_index))
            CFG_EXIT_DELAY:  exit_delay_in  = csr_wdata;
            CFG_KEY_TIMEOUT: key_timeout_in = csr_wdata;
            default:         ;
         endcase
      end
   end

   // handshake: the input stage advances whenever the result stage is free
   // or is being emptied this cycle
   assign step          = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || step;
   assign req_accept    = req_if.valid && req_if.ready;
   assign in_valid_in   = req_accept || (in_valid_ff && !step);
   assign out_valid_in  = step || (out_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         exit_delay_ff  <= EXIT_DELAY_RESET;
         key_timeout_ff <= KEY_TIMEOUT_RESET;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         exit_delay_ff  <= exit_delay_in;
         key_timeout_ff <= key_timeout_in;
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         button_ff <= req_if.button;
         motion_ff <= req_if.motion;
      end
      if (step) begin
         result_ff <= result;
      end
   end

   // key handling runs ahead of the mode logic within the same tick
   iac_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .button         (button_ff),
      .key_timeout_ms (key_timeout_ff),
      .key_event      (key_event)
   );

   iac_mode u_mode (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .motion        (motion_ff),
      .key_event     (key_event),
      .exit_delay_ms (exit_delay_ff),
      .result        (result)
   );

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.mode         = result_ff.mode;
   assign rsp_if.armed_led    = result_ff.armed_led;
   assign rsp_if.disarmed_led = result_ff.disarmed_led;
   assign rsp_if.buzzer       = result_ff.buzzer;

   // an empty result stage never blocks new requests
   `ASSERT_ALWAYS(a_ready_when_empty, clock, reset, !out_valid_ff |-> req_if.ready)
   // a held request is not lost while the response side stalls
   `ASSERT_NEXT(a_hold_input, clock, reset, in_valid_ff && !step, in_valid_ff)
   // siren only sounds in alarm
   `ASSERT_ALWAYS(a_buzzer_alarm, clock, reset,
                  !(out_valid_ff && result_ff.buzzer) || result_ff.mode == MODE_ALARM)
   // green LED excludes red LED and siren
   `ASSERT_ALWAYS(a_led_exclusive, clock, reset,
                  !(out_valid_ff && result_ff.disarmed_led) || (!result_ff.armed_led && !result_ff.buzzer))

endmodule

/* src/iac_seq.sv */
// Key sequence collector: gap timer, stored keys, arm/disarm detection.
// Depends on iac_pkg.
module iac_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [1:0]            button,
   input  logic [15:0]           key_timeout_ms,
   output iac_pkg::key_event_type key_event
);
   import iac_pkg::*;

   logic [1:0]  key0_ff, key0_in;
   logic [1:0]  key1_ff, key1_in;
   logic [1:0]  count_ff, count_in;
   logic [15:0] gap_ff, gap_in;
   logic        running_ff, running_in;
   logic [15:0] gap_inc;
   logic [1:0]  count_eff;
   logic        drop;

   always_comb begin
      gap_inc   = (running_ff && gap_ff != '1) ? gap_ff + 16'd1 : gap_ff;
      drop      = running_ff && (gap_inc > key_timeout_ms);
      count_eff = drop ? 2'd0 : count_ff;

      key0_in    = key0_ff;
      key1_in    = key1_ff;
      count_in   = count_ff;
      gap_in     = gap_ff;
      running_in = running_ff;
      key_event  = '0;

      if (step) begin
         gap_in = gap_inc;
         if (button != KEY_NONE) begin
            if (count_eff == LAST_KEY_POS) begin
               key_event.arm    = (key0_ff == KEY_ONE) && (key1_ff == KEY_TWO) &&
                                  (button == KEY_THREE);
               key_event.disarm = (key0_ff == KEY_THREE) && (key1_ff == KEY_TWO) &&
                                  (button == KEY_ONE);
               count_in   = 2'd0;
               gap_in     = 16'd0;
               running_in = 1'b0;
            end else begin
               if (count_eff == 2'd0) begin
                  key0_in = button;
               end else begin
                  key1_in = button;
               end
               count_in   = count_eff + 2'd1;
               gap_in     = 16'd0;
               running_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff    <= KEY_NONE;
         key1_ff    <= KEY_NONE;
         count_ff   <= 2'd0;
         gap_ff     <= 16'd0;
         running_ff <= 1'b0;
      end else begin
         key0_ff    <= key0_in;
         key1_ff    <= key1_in;
         count_ff   <= count_in;
         gap_ff     <= gap_in;
         running_ff <= running_in;
      end
   end

endmodule

/* src/iac_mode.sv */
// Mode logic: exit delay and blink timers, siren pattern, LED and buzzer levels.
// Depends on iac_pkg.
module iac_mode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   motion,
   input  iac_pkg::key_event_type key_event,
   input  logic [15:0]            exit_delay_ms,
   output iac_pkg::result_type    result
);
   import iac_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [15:0] exit_ff, exit_in;
   logic [8:0]  blink_ff, blink_in;
   logic        red_ff, red_in;
   logic [10:0] pos_ff, pos_in;
   logic        siren_ff, siren_in;
   logic        buzz_ff, buzz_in;

   mode_type    mode_v;
   logic [15:0] exit_v;
   logic [8:0]  blink_v;
   logic        red_v;
   logic [10:0] pos_v;
   logic        siren_v;
   logic        buzz_v;

   always_comb begin
      mode_v  = mode_ff;
      exit_v  = exit_ff;
      blink_v = blink_ff;
      red_v   = red_ff;
      pos_v   = pos_ff;
      siren_v = siren_ff;
      buzz_v  = buzz_ff;

      // timers advance first
      if (mode_ff == MODE_EXIT) begin
         if (exit_v != '1) exit_v = exit_v + 16'd1;
         if (blink_v != '1) blink_v = blink_v + 9'd1;
      end
      if (siren_ff && pos_v != '1) pos_v = pos_v + 11'd1;

      // key events
      if (key_event.arm && mode_v == MODE_DISARMED) begin
         mode_v  = MODE_EXIT;
         exit_v  = 16'd0;
         blink_v = 9'd0;
         red_v   = 1'b1;
         siren_v = 1'b0;
         pos_v   = 11'd0;
         buzz_v  = 1'b0;
      end
      if (key_event.disarm) begin
         mode_v  = MODE_DISARMED;
         siren_v = 1'b0;
         pos_v   = 11'd0;
         buzz_v  = 1'b0;
      end

      if (mode_v == MODE_EXIT) begin
         if (blink_v >= BLINK_HALF_MS) begin
            blink_v = 9'd0;
            red_v   = !red_v;
         end
         if (exit_v >= exit_delay_ms) begin
            red_v  = 1'b1;
            mode_v = MODE_ARMED;
         end
      end
      if (mode_v == MODE_ARMED && motion) mode_v = MODE_ALARM;

      if (mode_v == MODE_ALARM) begin
         if (!siren_v) begin
            siren_v = 1'b1;
            pos_v   = 11'd0;
            buzz_v  = 1'b1;
         end else begin
            if (pos_v >= SIREN_PERIOD_MS) pos_v = 11'd0;
            buzz_v = (pos_v < SIREN_OFF1_MS) ||
                     (pos_v >= SIREN_ON2_MS && pos_v < SIREN_OFF2_MS);
         end
      end

      mode_in  = step ? mode_v : mode_ff;
      exit_in  = step ? exit_v : exit_ff;
      blink_in = step ? blink_v : blink_ff;
      red_in   = step ? red_v : red_ff;
      pos_in   = step ? pos_v : pos_ff;
      siren_in = step ? siren_v : siren_ff;
      buzz_in  = step ? buzz_v : buzz_ff;

      result.mode = mode_v;
      unique case (mode_v)
         MODE_DISARMED: result.armed_led = 1'b0;
         MODE_EXIT:     result.armed_led = red_v;
         default:       result.armed_led = 1'b1;
      endcase
      result.disarmed_led = (mode_v == MODE_DISARMED);
      result.buzzer       = buzz_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_DISARMED;
         exit_ff  <= 16'd0;
         blink_ff <= 9'd0;
         red_ff   <= 1'b0;
         pos_ff   <= 11'd0;
         siren_ff <= 1'b0;
         buzz_ff  <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         exit_ff  <= exit_in;
         blink_ff <= blink_in;
         red_ff   <= red_in;
         pos_ff   <= pos_in;
         siren_ff <= siren_in;
         buzz_ff  <= buzz_in;
      end
   end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for intrusion_alarm_controller: random and directed key/motion ticks,
// every response checked against an in-bench model of modes, LEDs and siren.
// Depends on iac_pkg, the iac_req_if/iac_rsp_if interfaces and the controller RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import iac_pkg::*;

   // one millisecond tick as offered on the request channel
   typedef struct {
      logic [1:0] button;
      logic       motion;
   } tick_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   iac_req_if req_ch ();
   iac_rsp_if rsp_ch ();

   intrusion_alarm_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ticks waiting to be offered, and panel states waiting to come back
   tick_type   tick_backlog [$];
   result_type predicted_status [$];

   // bookkeeping shared by the processes
   int queued_total   = 0;   // ticks ever pushed to the backlog
   int requests_taken = 0;
   int responses_seen = 0;
   int csr_writes     = 0;
   int errors         = 0;
   int mode_ticks [4] = '{0, 0, 0, 0};
   int phase_target   = 0;   // queued_total at which the current phase stops
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int hold_request   = 0;   // long receiver stall asked by the sequencer
   int hold_left      = 0;   // remaining stall cycles, counted by the monitor
   int quiet_cycles   = 0;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RX_HOLD_CYCLES = 300;
   localparam int MAX_REPORTS    = 50;

   // ------------------------------------------------------------------
   // Alarm model state and register copies
   // ------------------------------------------------------------------
   mode_type    mode_q;
   logic [1:0]  key_buf [SEQUENCE_LENGTH];
   int          key_cnt;
   logic [15:0] gap_ms;
   logic        gap_run;
   logic [15:0] exit_ms;
   logic [8:0]  blink_ms;
   logic        red_led;
   logic [10:0] siren_ms;
   logic        siren_run;
   logic        buzz;
   logic [15:0] exit_delay_cfg;
   logic [15:0] key_timeout_cfg;

   function automatic void alarm_reset();
      mode_q          = MODE_DISARMED;
      key_buf         = '{KEY_NONE, KEY_NONE, KEY_NONE};
      key_cnt         = 0;
      gap_ms          = '0;
      gap_run         = 1'b0;
      exit_ms         = '0;
      blink_ms        = '0;
      red_led         = 1'b0;
      siren_ms        = '0;
      siren_run       = 1'b0;
      buzz            = 1'b0;
      exit_delay_cfg  = EXIT_DELAY_RESET;
      key_timeout_cfg = KEY_TIMEOUT_RESET;
   endfunction

   // mode change side effects: exit delay restarts its timers, leaving alarm kills the siren
   function automatic void change_mode(mode_type m);
      mode_q = m;
      if (m == MODE_EXIT) begin
         exit_ms  = '0;
         blink_ms = '0;
         red_led  = 1'b1;
      end
      if (m != MODE_ALARM) begin
         siren_run = 1'b0;
         siren_ms  = '0;
         buzz      = 1'b0;
      end
   endfunction

   function automatic void drop_keys();
      key_cnt = 0;
      gap_ms  = '0;
      gap_run = 1'b0;
   endfunction

   // One tick: timers first, then the key, then the mode logic.
   function automatic result_type alarm_tick(logic [1:0] button, logic motion);
      result_type r;
      if (gap_run && gap_ms != '1)
         gap_ms++;
      if (mode_q == MODE_EXIT) begin
         if (exit_ms != '1)
            exit_ms++;
         if (blink_ms != '1)
            blink_ms++;
      end
      if (siren_run && siren_ms != '1)
         siren_ms++;

      if (button != KEY_NONE) begin
         // a gap equal to the timeout keeps the partial code
         if (gap_run && gap_ms > key_timeout_cfg)
            drop_keys();
         key_buf[key_cnt] = button;
         key_cnt++;
         gap_ms  = '0;
         gap_run = 1'b1;
         if (key_cnt == SEQUENCE_LENGTH) begin
            if (key_buf[0] == KEY_ONE && key_buf[1] == KEY_TWO && key_buf[2] == KEY_THREE &&
                mode_q == MODE_DISARMED)
               change_mode(MODE_EXIT);
            if (key_buf[0] == KEY_THREE && key_buf[1] == KEY_TWO && key_buf[2] == KEY_ONE)
               change_mode(MODE_DISARMED);
            drop_keys();
         end
      end

      if (mode_q == MODE_EXIT) begin
         if (blink_ms >= BLINK_HALF_MS) begin
            blink_ms = '0;
            red_led  = !red_led;
         end
         if (exit_ms >= exit_delay_cfg) begin
            red_led = 1'b1;
            change_mode(MODE_ARMED);
         end
      end
      if (mode_q == MODE_ARMED && motion)
         change_mode(MODE_ALARM);
      if (mode_q == MODE_ALARM) begin
         if (!siren_run) begin
            siren_run = 1'b1;
            siren_ms  = '0;
            buzz      = 1'b1;
         end else begin
            if (siren_ms >= SIREN_PERIOD_MS)
               siren_ms = '0;
            buzz = (siren_ms < SIREN_OFF1_MS) ||
                   (siren_ms >= SIREN_ON2_MS && siren_ms < SIREN_OFF2_MS);
         end
      end

      r.mode         = mode_q;
      r.armed_led    = (mode_q == MODE_DISARMED) ? 1'b0 :
                       (mode_q == MODE_EXIT) ? red_led : 1'b1;
      r.disarmed_led = (mode_q == MODE_DISARMED);
      r.buzzer       = buzz;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Clock, watchdog
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // counts cycles in which neither channel moves a request or a response
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no traffic for %0d cycles, %0d responses outstanding",
                  $time, quiet_cycles, predicted_status.size());
         $display("** intrusion_alarm_controller: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Request driver: predicts on every accepted request, then, unless a request is
   // still held, offers the next tick from the backlog unless it idles this cycle.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      tick_type t;
      result_type r;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            r = alarm_tick(req_ch.button, req_ch.motion);
            predicted_status.push_back(r);
            mode_ticks[r.mode]++;
            requests_taken++;
         end
         // a held request stays put until taken
         if (!req_ch.valid || req_ch.ready) begin
            if (tick_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               t = tick_backlog.pop_front();
               req_ch.valid  <= 1'b1;
               req_ch.button <= t.button;
               req_ch.motion <= t.motion;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: field-by-field compare against the oldest prediction.
   // ------------------------------------------------------------------
   function automatic void check_field(string name, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
         if (errors < MAX_REPORTS)
            $display("%0t: %s mismatch on response %0d: expected %0d, got %0d",
                     $time, name, responses_seen, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_status.size() == 0) begin
               if (errors < MAX_REPORTS)
                  $display("%0t: response with no request outstanding: expected none, got mode %0d",
                           $time, rsp_ch.mode);
               errors++;
            end else begin
               want = predicted_status.pop_front();
               check_field("mode", want.mode, rsp_ch.mode);
               check_field("armed_led", want.armed_led, rsp_ch.armed_led);
               check_field("disarmed_led", want.disarmed_led, rsp_ch.disarmed_led);
               check_field("buzzer", want.buzzer, rsp_ch.buzzer);
            end
            responses_seen++;
         end
         // long stall on request of the sequencer, counted here
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_tick(logic [1:0] button, logic motion);
      tick_type t;
      t.button = button;
      t.motion = motion;
      tick_backlog.push_back(t);
      queued_total++;
   endtask

   // n ticks without a key, motion at the given percentage
   task automatic push_quiet(int n, int motion_pct);
      for (int i = 0; i < n; i++)
         push_tick(KEY_NONE, $urandom_range(99) < motion_pct);
   endtask

   // three keys on consecutive ticks
   task automatic push_seq(logic [1:0] k0, logic [1:0] k1, logic [1:0] k2);
      push_tick(k0, 1'b0);
      push_tick(k1, 1'b0);
      push_tick(k2, 1'b0);
   endtask

   // idle ticks between keys that keep a partial code alive
   function automatic int calm_gap();
      if (key_timeout_cfg == 0)
         return 0;
      return $urandom_range(0, (key_timeout_cfg > 12) ? 12 : key_timeout_cfg - 1);
   endfunction

   // gap right at the timeout (kept) or one past it (dropped); a calm gap for timeouts over 200
   function automatic int boundary_gap();
      if (key_timeout_cfg > 200)
         return calm_gap();
      if (key_timeout_cfg == 0)
         return $urandom_range(0, 1);
      return key_timeout_cfg - 1 + $urandom_range(0, 1);
   endfunction

   task automatic push_code(logic [1:0] k0, logic [1:0] k1, logic [1:0] k2, bit rough);
      push_tick(k0, $urandom_range(9) == 0);
      push_quiet((rough && $urandom_range(1)) ? boundary_gap() : calm_gap(), 10);
      push_tick(k1, $urandom_range(9) == 0);
      push_quiet((rough && $urandom_range(1)) ? boundary_gap() : calm_gap(), 10);
      push_tick(k2, $urandom_range(9) == 0);
   endtask

   // alarm length: mostly short, now and then long enough to pass the siren edges
   function automatic int siren_len();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60)
         return $urandom_range(0, 60);
      if (pick < 90)
         return $urandom_range(0, 350);
      return $urandom_range(300, 900);
   endfunction

   // arm, sit out (or cut short) the exit delay, maybe trip the alarm, disarm
   task automatic push_episode();
      int linger_ms;
      // flush a stray partial code left by noise
      if (key_timeout_cfg <= 40 && $urandom_range(9) < 7)
         push_quiet(key_timeout_cfg + 1, 0);
      push_code(KEY_ONE, KEY_TWO, KEY_THREE, $urandom_range(9) == 0);
      linger_ms = exit_delay_cfg + $urandom_range(0, 8);
      if ($urandom_range(3) == 0)
         linger_ms = $urandom_range(0, exit_delay_cfg);
      push_quiet(linger_ms, 0);
      if ($urandom_range(4) != 0) begin
         push_quiet($urandom_range(0, 6), 20);
         push_tick(KEY_NONE, 1'b1);
         push_quiet(siren_len(), 50);
      end
      push_code(KEY_THREE, KEY_TWO, KEY_ONE, $urandom_range(9) == 0);
   endtask

   task automatic push_noise();
      int n;
      n = $urandom_range(3, 15);
      for (int i = 0; i < n; i++)
         push_tick(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
   endtask

   // wait until every queued tick has come back as a response
   task automatic drain();
      while (responses_seen < queued_total)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(cfg_index_type idx, logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CFG_EXIT_DELAY)
         exit_delay_cfg = value;
      else
         key_timeout_cfg = value;
      csr_writes++;
   endtask

   // one register setting, filled with a random mix of scenarios
   task automatic run_phase(logic [15:0] exit_delay, logic [15:0] key_timeout, int items,
                            bit rx_hold, bit tx_pause);
      bit paused;
      int pick;
      paused = 1'b0;
      drain();
      write_csr(CFG_EXIT_DELAY, exit_delay);
      write_csr(CFG_KEY_TIMEOUT, key_timeout);
      phase_target = queued_total + items;
      if (rx_hold)
         hold_request = RX_HOLD_CYCLES;
      while (queued_total < phase_target) begin
         pick = $urandom_range(99);
         if (pick < 60)
            push_episode();
         else if (pick < 80)
            push_noise();
         else
            push_code(2'($urandom_range(1, 3)), 2'($urandom_range(1, 3)),
                      2'($urandom_range(1, 3)), 1'b1);
         // sender stops halfway until the block has answered everything
         if (tx_pause && !paused && 2 * (phase_target - queued_total) < items) begin
            drain();
            paused = 1'b1;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = 1'b0;
      csr_wdata     = '0;
      req_ch.valid  = 1'b0;
      req_ch.button = KEY_NONE;
      req_ch.motion = 1'b0;
      rsp_ch.ready  = 1'b0;
      alarm_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // idling profile one: sender idles a little, receiver a lot
      send_idle_pct = 12;
      recv_idle_pct = 73;

      // directed, reset settings
      push_tick(KEY_NONE, 1'b0);
      push_tick(KEY_NONE, 1'b1);                  // motion while disarmed is ignored
      push_seq(KEY_THREE, KEY_TWO, KEY_ONE);      // disarm while already disarmed
      push_seq(KEY_TWO, KEY_TWO, KEY_TWO);        // unknown code
      push_seq(KEY_ONE, KEY_TWO, KEY_THREE);      // arm: exit delay, red LED on
      push_tick(KEY_NONE, 1'b1);                  // motion during exit delay
      push_seq(KEY_ONE, KEY_TWO, KEY_THREE);      // arm code outside disarmed
      push_seq(KEY_THREE, KEY_TWO, KEY_ONE);      // disarm from exit delay
      push_seq(KEY_ONE, KEY_THREE, KEY_TWO);
      drain();
      // zero exit delay arms in the same tick as the last key
      write_csr(CFG_EXIT_DELAY, 16'd0);
      write_csr(CFG_KEY_TIMEOUT, 16'd5);
      push_seq(KEY_ONE, KEY_TWO, KEY_THREE);
      push_tick(KEY_NONE, 1'b1);                  // first alarm tick, siren on
      push_seq(KEY_THREE, KEY_TWO, KEY_ONE);

      // random phases, profile one; first one stalls the receiver for a long stretch
      run_phase(16'($urandom_range(0, 80)), 16'($urandom_range(1, 30)), 60, 1'b1, 1'b0);
      run_phase(16'($urandom_range(300, 650)), 16'hFFFF, 40, 1'b0, 1'b0);
      run_phase(16'd0, 16'd1, 40, 1'b0, 1'b0);

      // profile two: sender idles a lot, receiver a little
      drain();
      send_idle_pct = 73;
      recv_idle_pct = 12;
      run_phase(16'd301, 16'd0, 40, 1'b0, 1'b1);
      run_phase(16'd1, 16'($urandom_range(1, 30)), 40, 1'b0, 1'b1);
      run_phase(16'($urandom_range(0, 80)), 16'hFFFE, 40, 1'b1, 1'b0);
      run_phase(16'($urandom_range(0, 80)), 16'($urandom_range(1, 30)), 40, 1'b0, 1'b1);

      // no idling on either side
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(16'($urandom_range(0, 80)), 16'($urandom_range(1, 30)), 40, 1'b0, 1'b0);
      run_phase(16'($urandom_range(0, 80)), 16'($urandom_range(1, 30)), 40, 1'b0, 1'b0);
      run_phase(16'($urandom_range(290, 310)), 16'($urandom_range(1, 30)), 40, 1'b0, 1'b0);

      drain();
      repeat (8) @(posedge clock);
      if (predicted_status.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, predicted_status.size());
         errors++;
      end
      $display("Run covered %0d requests and %0d responses over %0d register writes, %0d errors.",
               requests_taken, responses_seen, csr_writes, errors);
      $display("Ticks per mode: disarmed %0d, exit delay %0d, armed %0d, alarm %0d.",
               mode_ticks[MODE_DISARMED], mode_ticks[MODE_EXIT], mode_ticks[MODE_ARMED],
               mode_ticks[MODE_ALARM]);
      if (errors == 0)
         $display("** intrusion_alarm_controller: PASSED **");
      else
         $display("** intrusion_alarm_controller: FAILED **");
      $finish;
   end

endmodule
